// ----- rtl/hsvb_pkg.sv -----
`timescale 1ns / 1ps

package hsvb_pkg;

    // store geometry
    localparam int MAX_PIXELS = 256;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    // fixed field widths
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int CH_W   = 13;
    localparam int OPD_W  = 17;
    localparam int PROD_W = 32;

    // fixed point constants
    localparam logic [CH_W-1:0]  Q12_ONE    = 13'd4096;
    localparam logic [CH_W-1:0]  DARK_LIMIT = 13'd5;
    localparam logic [OPD_W-1:0] HUE_WRAP8  = 17'd46080;  // 8 * 5760
    localparam logic [OPD_W-1:0] HUE_SECT4  = 17'd3840;   // 4 * 960
    localparam logic [OPD_W-1:0] F_RECIP    = 17'd34953;  // ceil(2^19 / 15)
    localparam logic [OPD_W-1:0] BYTE_MAX   = 17'd255;

    // register indexes
    localparam logic [1:0] CFG_DECAY = 2'd0;
    localparam logic [1:0] CFG_ORDER = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // byte orders
    localparam logic [1:0] ORD_RGB = 2'd1;
    localparam logic [1:0] ORD_GBR = 2'd2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_EMIT  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic {
        OP_MUL  = 1'b0,
        OP_CSUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [15:0]      decay;
        logic [1:0]       order;
        logic [CNT_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
    } t_pix;

    typedef struct packed {
        logic [23:0] word;
        logic        word_valid;
    } t_result;

    typedef struct packed {
        t_alu_op          op;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              ge;
        logic [PROD_W-1:0] res;
    } t_alu_rsp;

endpackage

// ----- rtl/hsvb_alu.sv -----
`timescale 1ns / 1ps

module hsvb_alu (
    input  hsvb_pkg::t_alu_req i_req,
    output hsvb_pkg::t_alu_rsp o_rsp
);
    import hsvb_pkg::*;

    logic             w_ge;
    logic [OPD_W-1:0] w_diff;

    // compare and conditional subtract
    assign w_ge   = (i_req.a >= i_req.b);
    assign w_diff = i_req.a - i_req.b;

    // shared multiply / compare-subtract
    always_comb begin
        o_rsp.ge = w_ge;
        unique case (i_req.op)
            OP_MUL:  o_rsp.res = PROD_W'(i_req.a[15:0]) * PROD_W'(i_req.b[15:0]);
            OP_CSUB: o_rsp.res = PROD_W'(w_ge ? w_diff : i_req.a);
        endcase
    end

endmodule

// ----- rtl/hsvb_store.sv -----
`timescale 1ns / 1ps

module hsvb_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [hsvb_pkg::ADDR_W-1:0]   i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [hsvb_pkg::ADDR_W-1:0]   i_wr_addr,
    input  hsvb_pkg::t_pix                i_wr_data,
    output hsvb_pkg::t_pix                o_rd_data
);
    import hsvb_pkg::*;

    t_pix                  r_mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_vld;
    t_pix                  r_rd;
    logic                  r_rd_vld;

    // pixel memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // per-entry written flags, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

// ----- rtl/hsvb_seq.sv -----
`timescale 1ns / 1ps

module hsvb_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvb_pkg::t_cfg        i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [7:0]            i_pixel_index,
    input  logic signed [15:0]    i_hue_in,
    input  logic signed [15:0]    i_sat_in,
    input  logic signed [15:0]    i_val_in,
    input  logic                  i_out_free,
    output logic                  o_done,
    output hsvb_pkg::t_result     o_result
);
    import hsvb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_WRAP = 6'b000100,
        ST_SECT = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    // multiply steps
    localparam logic [3:0] MS_F     = 4'd0;
    localparam logic [3:0] MS_SF    = 4'd1;
    localparam logic [3:0] MS_SF2   = 4'd2;
    localparam logic [3:0] MS_P     = 4'd3;
    localparam logic [3:0] MS_Q     = 4'd4;
    localparam logic [3:0] MS_T     = 4'd5;
    localparam logic [3:0] MS_R     = 4'd6;
    localparam logic [3:0] MS_G     = 4'd7;
    localparam logic [3:0] MS_B     = 4'd8;
    localparam logic [3:0] MS_DECAY = 4'd9;
    localparam logic [3:0] WRAP_LAST = 4'd3;
    localparam logic [3:0] SECT_LAST = 4'd2;

    t_state           r_state, n_state;
    logic [3:0]       r_step, n_step;
    t_req             r_req;
    logic [IDX_W-1:0] r_idx;
    logic             r_in_range;
    logic [OPD_W-1:0] r_acc;
    logic [CH_W-1:0]  r_sat_c, r_val_c;
    logic [CH_W-1:0]  r_h, r_s, r_v;
    logic [2:0]       r_sector;
    logic [CH_W-1:0]  r_f, r_sf, r_sf2, r_p, r_q, r_t, r_vdec;
    logic [7:0]       r_rc, r_gc, r_bc;

    logic             w_accept;
    logic             w_in_range;
    logic [OPD_W-1:0] w_hue_ofs;
    logic [CH_W-1:0]  w_cr, w_cg, w_cb;
    logic [CH_W-1:0]  w_vd;
    logic [23:0]      w_word;
    logic             w_wr_en;
    t_pix             w_wr_data;
    t_pix             w_rd_data;
    t_alu_req         w_alu_req;
    t_alu_rsp         w_alu_rsp;

    function automatic logic [CH_W-1:0] clamp_q12(input logic signed [15:0] x);
        logic [CH_W-1:0] res;
        if (x < 16'sd0) begin
            res = '0;
        end else if (x > 16'sd4096) begin
            res = Q12_ONE;
        end else begin
            res = x[CH_W-1:0];
        end
        return res;
    endfunction

    hsvb_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    hsvb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (ADDR_W'(i_pixel_index)),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (ADDR_W'(r_idx)),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // request decode at the handshake
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (CNT_W'(i_pixel_index) < i_cfg.count)
                        && (32'(i_pixel_index) < MAX_PIXELS);
    // hue plus six turns, always positive
    assign w_hue_ofs  = OPD_W'($signed({{2{i_hue_in[15]}}, i_hue_in}) + 18'sd34560);

    // sector to channel mapping
    always_comb begin
        if (r_s == '0) begin
            w_cr = r_v;
            w_cg = r_v;
            w_cb = r_v;
        end else begin
            case (r_sector)
                3'd0:    begin w_cr = r_v; w_cg = r_t; w_cb = r_p; end
                3'd1:    begin w_cr = r_q; w_cg = r_v; w_cb = r_p; end
                3'd2:    begin w_cr = r_p; w_cg = r_v; w_cb = r_t; end
                3'd3:    begin w_cr = r_p; w_cg = r_q; w_cb = r_v; end
                3'd4:    begin w_cr = r_t; w_cg = r_p; w_cb = r_v; end
                default: begin w_cr = r_v; w_cg = r_p; w_cb = r_q; end
            endcase
        end
    end

    // operand select for the shared unit
    always_comb begin
        w_alu_req.op = OP_CSUB;
        w_alu_req.a  = r_acc;
        w_alu_req.b  = '0;
        unique case (r_state)
            ST_WRAP: w_alu_req.b = HUE_WRAP8 >> r_step[1:0];
            ST_SECT: w_alu_req.b = HUE_SECT4 >> r_step[1:0];
            ST_MUL: begin
                w_alu_req.op = OP_MUL;
                case (r_step)
                    MS_F: begin
                        w_alu_req.a = OPD_W'({r_acc[9:0], 6'b0});
                        w_alu_req.b = F_RECIP;
                    end
                    MS_SF: begin
                        w_alu_req.a = OPD_W'(r_s);
                        w_alu_req.b = OPD_W'(r_f);
                    end
                    MS_SF2: begin
                        w_alu_req.a = OPD_W'(r_s);
                        w_alu_req.b = OPD_W'(Q12_ONE - r_f);
                    end
                    MS_P: begin
                        w_alu_req.a = OPD_W'(r_v);
                        w_alu_req.b = OPD_W'(Q12_ONE - r_s);
                    end
                    MS_Q: begin
                        w_alu_req.a = OPD_W'(r_v);
                        w_alu_req.b = OPD_W'(Q12_ONE - r_sf);
                    end
                    MS_T: begin
                        w_alu_req.a = OPD_W'(r_v);
                        w_alu_req.b = OPD_W'(Q12_ONE - r_sf2);
                    end
                    MS_R: begin
                        w_alu_req.a = OPD_W'(w_cr);
                        w_alu_req.b = BYTE_MAX;
                    end
                    MS_G: begin
                        w_alu_req.a = OPD_W'(w_cg);
                        w_alu_req.b = BYTE_MAX;
                    end
                    MS_B: begin
                        w_alu_req.a = OPD_W'(w_cb);
                        w_alu_req.b = BYTE_MAX;
                    end
                    MS_DECAY: begin
                        w_alu_req.a = OPD_W'(r_v);
                        w_alu_req.b = OPD_W'(i_cfg.decay);
                    end
                    default: begin
                        w_alu_req.a = '0;
                        w_alu_req.b = '0;
                    end
                endcase
            end
            default: w_alu_req.b = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    if (!w_in_range || t_req'(i_req_type) == REQ_NONE
                            || t_req'(i_req_type) == REQ_CLEAR) begin
                        n_state = ST_FIN;
                    end else if (t_req'(i_req_type) == REQ_WRITE) begin
                        n_state = ST_WRAP;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_WRAP: begin
                n_step = r_step + 4'd1;
                if (r_step == WRAP_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_READ: begin
                n_step  = '0;
                n_state = ST_SECT;
            end
            ST_SECT: begin
                n_step = r_step + 4'd1;
                if (r_step == SECT_LAST) begin
                    n_step  = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + 4'd1;
                if (r_step == MS_DECAY) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // decayed value with dark floor
    assign w_vd = w_alu_rsp.res[28:16];

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req      <= t_req'(i_req_type);
            r_idx      <= i_pixel_index;
            r_in_range <= w_in_range;
            r_acc      <= w_hue_ofs;
            r_sat_c    <= clamp_q12(i_sat_in);
            r_val_c    <= clamp_q12(i_val_in);
        end
        unique case (r_state)
            ST_WRAP: r_acc <= w_alu_rsp.res[OPD_W-1:0];
            ST_READ: begin
                r_h      <= w_rd_data.hue;
                r_s      <= w_rd_data.sat;
                r_v      <= w_rd_data.val;
                r_acc    <= OPD_W'(w_rd_data.hue);
                r_sector <= '0;
            end
            ST_SECT: begin
                r_acc    <= w_alu_rsp.res[OPD_W-1:0];
                r_sector <= {r_sector[1:0], w_alu_rsp.ge};
            end
            ST_MUL: begin
                case (r_step)
                    MS_F:     r_f    <= w_alu_rsp.res[31:19];
                    MS_SF:    r_sf   <= w_alu_rsp.res[24:12];
                    MS_SF2:   r_sf2  <= w_alu_rsp.res[24:12];
                    MS_P:     r_p    <= w_alu_rsp.res[24:12];
                    MS_Q:     r_q    <= w_alu_rsp.res[24:12];
                    MS_T:     r_t    <= w_alu_rsp.res[24:12];
                    MS_R:     r_rc   <= w_alu_rsp.res[19:12];
                    MS_G:     r_gc   <= w_alu_rsp.res[19:12];
                    MS_B:     r_bc   <= w_alu_rsp.res[19:12];
                    MS_DECAY: r_vdec <= (w_vd < DARK_LIMIT) ? '0 : w_vd;
                    default:  r_vdec <= r_vdec;
                endcase
            end
            default: ;
        endcase
    end

    // byte packing
    always_comb begin
        case (i_cfg.order)
            ORD_RGB: w_word = {r_rc, r_gc, r_bc};
            ORD_GBR: w_word = {r_gc, r_bc, r_rc};
            default: w_word = {r_gc, r_rc, r_bc};
        endcase
    end

    // store write-back
    always_comb begin
        case (r_req)
            REQ_WRITE: w_wr_data = '{hue: r_acc[CH_W-1:0], sat: r_sat_c, val: r_val_c};
            REQ_EMIT:  w_wr_data = '{hue: r_h, sat: r_s, val: r_vdec};
            default:   w_wr_data = '0;
        endcase
    end

    assign o_done  = (r_state == ST_FIN) && i_out_free;
    assign w_wr_en = o_done && r_in_range && (r_req != REQ_NONE);

    assign o_result.word       = (r_in_range && r_req == REQ_EMIT) ? w_word : '0;
    assign o_result.word_valid = r_in_range && (r_req == REQ_EMIT || r_req == REQ_CLEAR);

endmodule

// ----- rtl/hsv_pixel_buffer_with_decay_top.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// request   | i_in_valid / o_in_ready   | i_req_type i_pixel_index i_hue_in i_sat_in i_val_in
// result    | o_out_valid / i_out_ready | o_pixel_word o_word_valid
// config    | i_cfg_we                  | i_cfg_index i_cfg_data
//
// clear, ignored or unused requests go from acceptance straight to the finish state; a write
// passes through 4 hue wrap steps and the finish, an emit through one store read,
// 3 sector steps, 10 steps of the shared multiplier and the finish
// the wrap, sector and multiply steps share one multiply / compare-subtract unit; ready again the cycle after
// the result is handed to the output register, which holds it until taken
// reset is synchronous, active low; pixel entries read as zero until written (no clearing pass)
`timescale 1ns / 1ps

module hsv_pixel_buffer_with_decay_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_pixel_index,
    input  logic signed [15:0] i_hue_in,
    input  logic signed [15:0] i_sat_in,
    input  logic signed [15:0] i_val_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_pixel_word,
    output logic               o_word_valid
);
    import hsvb_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_done;
    t_result w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay <= 16'hFFFF;
            r_cfg.order <= 2'd0;
            r_cfg.count <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECAY: r_cfg.decay <= i_cfg_data;
                CFG_ORDER: r_cfg.order <= i_cfg_data[1:0];
                CFG_COUNT: r_cfg.count <= i_cfg_data[CNT_W-1:0];
                default:   r_cfg.count <= r_cfg.count;
            endcase
        end
    end

    hsvb_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pixel_index (i_pixel_index),
        .i_hue_in      (i_hue_in),
        .i_sat_in      (i_sat_in),
        .i_val_in      (i_val_in),
        .i_out_free    (w_out_free),
        .o_done        (w_done),
        .o_result      (w_result)
    );

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_word = r_out.word;
    assign o_word_valid = r_out.word_valid;

endmodule

// ----- rtl/hsvb_checker.sv -----
`timescale 1ns / 1ps

module hsvb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_pixel_word,
    input logic        o_word_valid
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_word)
            && $stable(o_word_valid))
        else $error("result changed while stalled");

    // only an emit gives a non-zero word, and it is always marked for sending
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_word_valid |-> o_pixel_word == 24'd0)
        else $error("unsent result carries a colour");

    // one transaction at a time: busy after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted back to back");

    // no result can be ready in the cycle after acceptance with an empty output
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind hsv_pixel_buffer_with_decay_top hsvb_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_pixel_word (o_pixel_word),
    .o_word_valid (o_word_valid)
);

// ----- bench/tb_hsv_pixel_buffer_with_decay_top.sv -----
`timescale 1ns / 1ps

module tb_hsv_pixel_buffer_with_decay_top;

    import hsvb_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          HUE_TURN     = 5760;
    localparam int unsigned SECTOR_SPAN  = 960;
    localparam int unsigned UNIT_Q12     = Q12_ONE;

    typedef struct {
        t_req               req;
        logic [7:0]         idx;
        logic signed [15:0] hue;
        logic signed [15:0] sat;
        logic signed [15:0] val;
    } t_pixel_req;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_DECAY;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [23:0] o_pixel_word;
    logic        o_word_valid;

    t_pixel_req on_bus = '{REQ_NONE, 8'd0, 16'sd0, 16'sd0, 16'sd0};

    // stimulus waiting for the driver and results waiting for the monitor
    t_pixel_req pixel_reqs[$];
    t_result    expected_words[$];
    t_result    oldest_word;

    // shadow of the pixel store and the registers
    logic [CH_W-1:0] hue_mem [MAX_PIXELS];
    logic [CH_W-1:0] sat_mem [MAX_PIXELS];
    logic [CH_W-1:0] val_mem [MAX_PIXELS];
    logic [15:0]     decay_q16   = 16'hFFFF;
    logic [1:0]      byte_order  = 2'd0;
    logic [8:0]      pixel_count = 9'd256;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    hsv_pixel_buffer_with_decay_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (on_bus.req),
        .i_pixel_index (on_bus.idx),
        .i_hue_in      (on_bus.hue),
        .i_sat_in      (on_bus.sat),
        .i_val_in      (on_bus.val),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_pixel_word  (o_pixel_word),
        .o_word_valid  (o_word_valid)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned clamp_q12(logic signed [15:0] x);
        int xi;
        xi = x;
        if (xi < 0) return 0;
        if (xi > int'(UNIT_Q12)) return UNIT_Q12;
        return xi;
    endfunction

    function automatic logic [7:0] chan_to_byte(int unsigned c);
        int unsigned b;
        b = (c * 255) >> 12;
        return b[7:0];
    endfunction

    // six-sector hsv to rgb, bytes packed in the current order
    function automatic logic [23:0] hsv_to_packed(int unsigned h, int unsigned s,
                                                  int unsigned v);
        int unsigned r, g, b, sector, rem, f, p, q, t;
        logic [7:0]  rb, gb, bb;
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            sector = h / SECTOR_SPAN;
            rem    = h % SECTOR_SPAN;
            f      = (rem << 12) / SECTOR_SPAN;
            p      = (v * (UNIT_Q12 - s)) >> 12;
            q      = (v * (UNIT_Q12 - ((s * f) >> 12))) >> 12;
            t      = (v * (UNIT_Q12 - ((s * (UNIT_Q12 - f)) >> 12))) >> 12;
            case (sector)
                0: begin r = v; g = t; b = p; end
                1: begin r = q; g = v; b = p; end
                2: begin r = p; g = v; b = t; end
                3: begin r = p; g = q; b = v; end
                4: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
        end
        rb = chan_to_byte(r);
        gb = chan_to_byte(g);
        bb = chan_to_byte(b);
        case (byte_order)
            ORD_RGB: return {rb, gb, bb};
            ORD_GBR: return {gb, bb, rb};
            default: return {gb, rb, bb};
        endcase
    endfunction

    // applies one request to the shadow store and returns the word it answers
    function automatic t_result apply_request(t_pixel_req item);
        t_result     res;
        int          hue_wrapped;
        int unsigned active, v;
        res    = '0;
        active = (pixel_count < MAX_PIXELS) ? pixel_count : MAX_PIXELS;
        if (item.idx < active) begin
            case (item.req)
                REQ_WRITE: begin
                    hue_wrapped = int'(item.hue) % HUE_TURN;
                    if (hue_wrapped < 0) hue_wrapped += HUE_TURN;
                    hue_mem[item.idx] = hue_wrapped[CH_W-1:0];
                    sat_mem[item.idx] = CH_W'(clamp_q12(item.sat));
                    val_mem[item.idx] = CH_W'(clamp_q12(item.val));
                end
                REQ_EMIT: begin
                    v = val_mem[item.idx];
                    res.word       = hsv_to_packed(hue_mem[item.idx], sat_mem[item.idx], v);
                    res.word_valid = 1'b1;
                    v = (v * decay_q16) >> 16;
                    if (v < DARK_LIMIT) v = 0;
                    val_mem[item.idx] = v[CH_W-1:0];
                end
                REQ_CLEAR: begin
                    hue_mem[item.idx] = '0;
                    sat_mem[item.idx] = '0;
                    val_mem[item.idx] = '0;
                    res.word_valid    = 1'b1;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_words.push_back(apply_request(on_bus));
            end
            if (!in_valid || o_in_ready) begin
                if (pixel_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    on_bus   <= pixel_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result with none pending, word %06h valid %0b",
                             $time, o_pixel_word, o_word_valid);
                    err_count++;
                end else begin
                    oldest_word = expected_words.pop_front();
                    if (o_pixel_word !== oldest_word.word) begin
                        $display("%0t: pixel_word mismatch, expected %06h actual %06h",
                                 $time, oldest_word.word, o_pixel_word);
                        err_count++;
                    end
                    if (o_word_valid !== oldest_word.word_valid) begin
                        $display("%0t: word_valid mismatch, expected %0b actual %0b",
                                 $time, oldest_word.word_valid, o_word_valid);
                        err_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_req(t_req req, logic [7:0] idx, logic signed [15:0] hue,
                            logic signed [15:0] sat, logic signed [15:0] val);
        t_pixel_req item;
        item.req = req;
        item.idx = idx;
        item.hue = hue;
        item.sat = sat;
        item.val = val;
        pixel_reqs.push_back(item);
    endtask

    // saturation or value: mostly in range, some edges, some raw 16-bit
    function automatic logic [15:0] rand_q12_field();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 16'($urandom_range(0, UNIT_Q12));
        if (roll < 80) return $urandom_range(0, 1) ? 16'(UNIT_Q12) : 16'd0;
        return 16'($urandom);
    endfunction

    // random requests, most aimed at a small window of active pixels
    task automatic queue_random(int n);
        t_pixel_req  item;
        int unsigned active, lo, hi, roll;
        active = (pixel_count < MAX_PIXELS) ? pixel_count : MAX_PIXELS;
        if (active == 0) active = MAX_PIXELS;
        lo = $urandom_range(0, active - 1);
        hi = (lo + 15 > active - 1) ? active - 1 : lo + 15;
        repeat (n) begin
            roll     = $urandom_range(0, 99);
            item.req = (roll < 40) ? REQ_WRITE :
                       (roll < 85) ? REQ_EMIT  :
                       (roll < 95) ? REQ_CLEAR : REQ_NONE;
            item.idx = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(lo, hi))
                                                 : 8'($urandom_range(0, 255));
            item.hue = $urandom_range(0, 1) ? 16'($urandom_range(0, HUE_TURN - 1))
                                            : 16'($urandom);
            item.sat = rand_q12_field();
            item.val = rand_q12_field();
            pixel_reqs.push_back(item);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_DECAY: decay_q16   = data;
            CFG_ORDER: byte_order  = data[1:0];
            CFG_COUNT: pixel_count = data[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pixel_reqs.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [15:0] decay, logic [1:0] order, logic [15:0] count,
                             int n, int send_pct, int recv_pct);
        write_reg(CFG_DECAY, decay);
        write_reg(CFG_ORDER, {14'd0, order});
        write_reg(CFG_COUNT, count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge i_clk);
        queue_random(n);
        wait_drained();
    endtask

    // sequence of phases
    initial begin
        foreach (hue_mem[i]) begin
            hue_mem[i] = '0;
            sat_mem[i] = '0;
            val_mem[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, clamping, hue wrap, dark cut-off, clear, unused type
        send_idle_pct = 13;
        recv_idle_pct = 84;
        @(negedge i_clk);
        push_req(REQ_WRITE, 8'd0,   16'sd0,     16'sd4096,  16'sd4096);
        push_req(REQ_EMIT,  8'd0,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd1,   16'h8000,   16'h8000,   16'h7FFF);
        push_req(REQ_EMIT,  8'd1,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd2,   16'h7FFF,   16'h7FFF,   16'hFFFF);
        push_req(REQ_EMIT,  8'd2,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd3,   16'hFFFF,   16'sd4097,  16'sd4096);
        push_req(REQ_EMIT,  8'd3,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd4,   16'sd5760,  16'sd2048,  16'sd3000);
        push_req(REQ_EMIT,  8'd4,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd5,   -16'sd5760, 16'sd1,     16'sd1);
        push_req(REQ_EMIT,  8'd5,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_EMIT,  8'd255, 16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd255, 16'sd5759,  16'sd4096,  16'sd4096);
        push_req(REQ_EMIT,  8'd255, 16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_CLEAR, 8'd255, 16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_EMIT,  8'd255, 16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_NONE,  8'd0,   16'($urandom), 16'($urandom), 16'($urandom));
        push_req(REQ_EMIT,  8'd0,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd7,   16'sd1920,  16'sd4096,  16'sd5);
        push_req(REQ_EMIT,  8'd7,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_EMIT,  8'd7,   16'sd0,     16'sd0,     16'sd0);
        push_req(REQ_WRITE, 8'd8,   16'sd2880,  16'sd4096,  16'sd4096);
        push_req(REQ_EMIT,  8'd8,   16'sd0,     16'sd0,     16'sd0);
        wait_drained();

        // random phases across register settings and handshake pressure
        run_phase(16'd52000, 2'd1, 16'd256, 220, 13, 84);
        run_phase(16'd0,     2'd2, 16'd1,   120, 13, 84);
        run_phase(16'hFFFF,  2'd3, 16'd511, 220, 84, 13);
        run_phase(16'($urandom), 2'd0, 16'($urandom_range(2, 255)), 220, 84, 13);
        run_phase(16'd40000, 2'd1, 16'd0,   30,  84, 13);
        run_phase(16'd30000, 2'd1, 16'd256, 230, 0, 0);
        run_phase(16'($urandom), 2'd2, 16'd200, 230, 0, 0);

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
